FILE: src/sorted_priority_queue_assert.svh
// Assertion macros for the sorted priority queue.
// Used by the top level only; no other dependencies.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTH
// Overlapping implication: the consequent is checked in the same cycle.
`define SPQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication: the consequent is checked in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SPQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: src/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; used by spq_cell and sorted_priority_queue.
package spq_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int DEF_TAG_BITS = 64;
    localparam int VALUE_W      = 64;
    localparam int PRI_W        = 32;
    localparam int COUNT_OUT_W  = 5;

    typedef enum logic [1:0] {
        OP_ENQ   = 2'd0,
        OP_DEQ   = 2'd1,
        OP_CHG   = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_EMPTY    = 2'd1,
        STAT_NOTFOUND = 2'd2,
        STAT_FULL     = 2'd3
    } t_status;

    // Command seen by every cell during the execute cycle.
    typedef struct packed {
        t_op  op;
        logic apply;
    } t_cell_ctl;

    // Flags handed from one cell to the next one down the row.
    typedef struct packed {
        logic occ;     // this cell holds an entry
        logic ahead;   // this cell's entry sorts ahead of the command entry
        logic found;   // a change-priority match sits at this cell or above
    } t_chain;

endpackage

FILE: src/spq_cell.sv
// One slot of the sorted queue: holds a tag and a priority and trades
// entries with its neighbors. Depends on spq_pkg.
module spq_cell import spq_pkg::*; #(
    parameter int TAG_BITS = DEF_TAG_BITS
) (
    input  logic                       i_clk,
    input  t_cell_ctl                  i_ctl,
    input  logic [TAG_BITS-1:0]        i_tag,
    input  logic signed [PRI_W-1:0]    i_pri,
    input  logic                       i_occ,
    input  logic [TAG_BITS-1:0]        i_left_tag,
    input  logic signed [PRI_W-1:0]    i_left_pri,
    input  logic [TAG_BITS-1:0]        i_right_tag,
    input  logic signed [PRI_W-1:0]    i_right_pri,
    input  t_chain                     i_chain,
    output t_chain                     o_chain,
    output logic [TAG_BITS-1:0]        o_tag,
    output logic signed [PRI_W-1:0]    o_pri
);

    logic [TAG_BITS-1:0]     r_tag;
    logic signed [PRI_W-1:0] r_pri;
    logic                    w_before;
    logic                    w_hit;
    logic                    w_insert;
    logic                    w_take_left;

    // The stored entry sorts ahead of the command entry.
    assign w_before = i_occ && ((r_pri < i_pri) || ((r_pri == i_pri) && (i_tag > r_tag)));
    // First-match candidate for a change of priority.
    assign w_hit    = i_occ && (r_tag == i_tag) && (i_pri < r_pri);

    // The insert point is the first cell whose entry does not sort ahead.
    assign w_insert    = !w_before && i_chain.ahead;
    assign w_take_left = !w_before && !w_insert &&
                         ((i_ctl.op == OP_ENQ) ? i_chain.occ : !i_chain.found);

    assign o_chain.occ   = i_occ;
    assign o_chain.ahead = w_before;
    assign o_chain.found = i_chain.found | w_hit;
    assign o_tag = r_tag;
    assign o_pri = r_pri;

    always_ff @(posedge i_clk) begin
        if (i_ctl.apply) begin
            case (i_ctl.op) inside
                OP_ENQ, OP_CHG: begin
                    if (w_insert) begin
                        r_tag <= i_tag;
                        r_pri <= i_pri;
                    end else if (w_take_left) begin
                        r_tag <= i_left_tag;
                        r_pri <= i_left_pri;
                    end
                end
                OP_DEQ: begin
                    r_tag <= i_right_tag;
                    r_pri <= i_right_pri;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: src/sorted_priority_queue.sv
// Top level of the sorted priority queue: command handshake, count and a
// row of spq_cell slots. Depends on spq_pkg, spq_cell and the assertion header.
//
//   Channel   Direction  Handshake                    Payload
//   command   in         start high while busy low    i_operation, i_item_value,
//                                                     i_item_priority
//   result    out        o_done high for one cycle    o_removed_value, o_status,
//                                                     o_head_value, o_head_priority,
//                                                     o_entry_count, o_is_empty
//
// For every command, the beat is captured at the accepting edge, all cells
// compare and shift together in the following execute cycle, and the result
// is shown in the cycle after that, during which a new command may already be
// accepted. The execute cycle is set by the compare chain that runs through
// the row of cells. Reset is synchronous and active low; it empties the queue
// at once, with no clearing pass. The receiver cannot stall results.

`include "sorted_priority_queue_assert.svh"

module sorted_priority_queue import spq_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int TAG_BITS = DEF_TAG_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_operation,
    input  logic [VALUE_W-1:0]         i_item_value,
    input  logic signed [PRI_W-1:0]    i_item_priority,
    output logic                       o_done,
    output logic [VALUE_W-1:0]         o_removed_value,
    output logic [1:0]                 o_status,
    output logic [VALUE_W-1:0]         o_head_value,
    output logic signed [PRI_W-1:0]    o_head_priority,
    output logic [COUNT_OUT_W-1:0]     o_entry_count,
    output logic                       o_is_empty
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state                  r_state;
    logic                    r_done;
    logic [CNT_W-1:0]        r_count;
    t_op                     r_op;
    logic [TAG_BITS-1:0]     r_tag;
    logic signed [PRI_W-1:0] r_pri;
    logic [VALUE_W-1:0]      r_removed;
    t_status                 r_status;

    logic [CNT_W-1:0]        n_count;
    t_status                 n_status;
    logic [VALUE_W-1:0]      n_removed;

    t_cell_ctl               w_ctl;
    logic [TAG_BITS-1:0]     w_tag [CAPACITY];
    logic signed [PRI_W-1:0] w_pri [CAPACITY];
    t_chain                  w_chain [CAPACITY+1];
    logic [CAPACITY-1:0]     w_occ;
    logic                    w_full;
    logic                    w_empty;
    logic [CNT_W+COUNT_OUT_W-1:0] w_count_wide;

    assign w_full  = (r_count >= CNT_W'(CAPACITY));
    assign w_empty = (r_count == '0);

    // Cell zero sees an imaginary neighbor above it that sorts ahead of
    // everything and holds no match, so it becomes the insert point whenever
    // its own entry does not sort ahead.
    assign w_chain[0] = '{occ: 1'b1, ahead: 1'b1, found: 1'b0};

    always_comb begin
        w_ctl.op    = r_op;
        w_ctl.apply = 1'b0;
        n_count     = r_count;
        n_status    = STAT_OK;
        n_removed   = '0;
        case (r_op)
            OP_ENQ: begin
                if (w_full) begin
                    n_status = STAT_FULL;
                end else begin
                    w_ctl.apply = (r_state == S_EXEC);
                    n_count     = r_count + CNT_W'(1);
                end
            end
            OP_DEQ: begin
                if (w_empty) begin
                    n_status = STAT_EMPTY;
                end else begin
                    w_ctl.apply = (r_state == S_EXEC);
                    n_count     = r_count - CNT_W'(1);
                    n_removed   = VALUE_W'(w_tag[0]);
                end
            end
            OP_CHG: begin
                // A match exists only among occupied cells, so it implies a
                // nonempty queue; the count does not change.
                if (w_empty) begin
                    n_status = STAT_EMPTY;
                end else if (w_chain[CAPACITY].found) begin
                    w_ctl.apply = (r_state == S_EXEC);
                end else begin
                    n_status = STAT_NOTFOUND;
                end
            end
            default: begin
                n_count = '0;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [TAG_BITS-1:0]     w_ltag;
            logic signed [PRI_W-1:0] w_lpri;
            logic [TAG_BITS-1:0]     w_rtag;
            logic signed [PRI_W-1:0] w_rpri;

            assign w_occ[gi] = (CNT_W'(gi) < r_count);

            if (gi == 0) begin : g_first
                assign w_ltag = r_tag;
                assign w_lpri = r_pri;
            end else begin : g_mid
                assign w_ltag = w_tag[gi-1];
                assign w_lpri = w_pri[gi-1];
            end

            // The last cell has no right neighbor; it keeps its own entry,
            // which leaves the occupied range after a dequeue anyway.
            if (gi == CAPACITY - 1) begin : g_last
                assign w_rtag = w_tag[gi];
                assign w_rpri = w_pri[gi];
            end else begin : g_inner
                assign w_rtag = w_tag[gi+1];
                assign w_rpri = w_pri[gi+1];
            end

            spq_cell #(
                .TAG_BITS(TAG_BITS)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_tag      (r_tag),
                .i_pri      (r_pri),
                .i_occ      (w_occ[gi]),
                .i_left_tag (w_ltag),
                .i_left_pri (w_lpri),
                .i_right_tag(w_rtag),
                .i_right_pri(w_rpri),
                .i_chain    (w_chain[gi]),
                .o_chain    (w_chain[gi+1]),
                .o_tag      (w_tag[gi]),
                .o_pri      (w_pri[gi])
            );
        end
    endgenerate

    // Control state, the count and the registered result fields.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_done <= 1'b0;
                    if (start) begin
                        r_state <= S_EXEC;
                        r_op    <= t_op'(i_operation);
                        r_tag   <= i_item_value[TAG_BITS-1:0];
                        r_pri   <= i_item_priority;
                    end
                end
                S_EXEC: begin
                    r_state   <= S_IDLE;
                    r_done    <= 1'b1;
                    r_count   <= n_count;
                    r_status  <= n_status;
                    r_removed <= n_removed;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy = (r_state == S_EXEC);

    // The head and count fields come straight from the cell row and the
    // count, which already hold the state after the step.
    assign w_count_wide    = {{COUNT_OUT_W{1'b0}}, r_count};
    assign o_done          = r_done;
    assign o_removed_value = r_removed;
    assign o_status        = r_status;
    assign o_head_value    = w_empty ? '0 : VALUE_W'(w_tag[0]);
    assign o_head_priority = w_empty ? '0 : w_pri[0];
    assign o_entry_count   = w_count_wide[COUNT_OUT_W-1:0];
    assign o_is_empty      = w_empty;

    `SPQ_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, start && !busy, busy,
                     "accepted beat did not enter execute")
    `SPQ_ASSERT_NEXT(a_exec_done, i_clk, i_rst_n, busy, o_done && !busy,
                     "execute did not produce one result")
    `SPQ_ASSERT_SAME(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY),
                     "count exceeds capacity")
    `SPQ_ASSERT_SAME(a_full_status, i_clk, i_rst_n, o_done && (o_status == STAT_FULL),
                     r_count == CNT_W'(CAPACITY), "full status with room left")

endmodule
